// ===== sv/qmcds_pkg.sv =====
// ----------------------------------------------------------------------------
// qmcds_pkg: shared definitions of the digital shift randomizer
// Widths, method codes, register indexes, reset values and the control
// structs that pass between the sequencer and its serial units.
// ----------------------------------------------------------------------------
package qmcds_pkg;

  localparam int unsigned DataW           = 32;
  localparam int unsigned MethodW         = 2;
  localparam int unsigned BaseW           = 17;
  localparam int unsigned DcntW           = 6;
  localparam int unsigned ScaleW          = 33;
  localparam int unsigned AccW            = 64;
  localparam int unsigned CfgDataW        = 64;
  localparam int unsigned CfgAddrW        = 5;
  localparam int unsigned RegIdxW         = 2;
  localparam int unsigned FracBitsDefault = 32;
  localparam int unsigned MaxDigits       = 32;

  localparam logic [MethodW-1:0] MethodNone    = 2'd0;
  localparam logic [MethodW-1:0] MethodAdd     = 2'd1;
  localparam logic [MethodW-1:0] MethodDigital = 2'd2;

  localparam logic [RegIdxW-1:0] RegMethod = 2'd0;
  localparam logic [RegIdxW-1:0] RegBase   = 2'd1;
  localparam logic [RegIdxW-1:0] RegDcnt   = 2'd2;
  localparam logic [RegIdxW-1:0] RegScale  = 2'd3;

  localparam logic [BaseW-1:0]   BaseTwo       = 17'd2;
  localparam logic [MethodW-1:0] MethodReset   = MethodNone;
  localparam logic [BaseW-1:0]   BaseReset     = BaseTwo;
  localparam logic [DcntW-1:0]   DcntReset     = 6'd32;
  localparam logic [ScaleW-1:0]  ScaleReset    = 33'h1_0000_0000;

  typedef struct packed {
    logic [MethodW-1:0] method;
    logic [BaseW-1:0]   base;
    logic [DcntW-1:0]   digit_count;
    logic [ScaleW-1:0]  scale;
  } cfg_t;

  // Load and step strobes of a shift-and-add or restoring unit.
  typedef struct packed {
    logic load;
    logic step;
  } seq_ctrl_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic step;
    logic last;
  } mac_ctrl_t;

endpackage

// ===== sv/qmcds_cfg.sv =====
// ----------------------------------------------------------------------------
// qmcds_cfg: configuration registers
// APB-style register file holding method, base, digit count and scale.
// ----------------------------------------------------------------------------
module qmcds_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [qmcds_pkg::CfgAddrW-1:0]      paddr,
  input  logic [qmcds_pkg::CfgDataW-1:0]      pwdata,
  output logic [qmcds_pkg::CfgDataW-1:0]      prdata,
  output logic                                pready,
  output qmcds_pkg::cfg_t                     cfg_o
);

  qmcds_pkg::cfg_t                    cfg_q;
  logic [qmcds_pkg::RegIdxW-1:0]      reg_idx;
  logic                               wr_en;

  assign reg_idx = paddr[qmcds_pkg::CfgAddrW-1:qmcds_pkg::CfgAddrW-qmcds_pkg::RegIdxW];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.method      <= qmcds_pkg::MethodReset;
      cfg_q.base        <= qmcds_pkg::BaseReset;
      cfg_q.digit_count <= qmcds_pkg::DcntReset;
      cfg_q.scale       <= qmcds_pkg::ScaleReset;
    end else if (wr_en) begin
      case (reg_idx)
        qmcds_pkg::RegMethod: cfg_q.method      <= pwdata[qmcds_pkg::MethodW-1:0];
        qmcds_pkg::RegBase:   cfg_q.base        <= pwdata[qmcds_pkg::BaseW-1:0];
        qmcds_pkg::RegDcnt:   cfg_q.digit_count <= pwdata[qmcds_pkg::DcntW-1:0];
        qmcds_pkg::RegScale:  cfg_q.scale       <= pwdata[qmcds_pkg::ScaleW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      qmcds_pkg::RegMethod: prdata = qmcds_pkg::CfgDataW'(cfg_q.method);
      qmcds_pkg::RegBase:   prdata = qmcds_pkg::CfgDataW'(cfg_q.base);
      qmcds_pkg::RegDcnt:   prdata = qmcds_pkg::CfgDataW'(cfg_q.digit_count);
      qmcds_pkg::RegScale:  prdata = qmcds_pkg::CfgDataW'(cfg_q.scale);
      default:              prdata = '0;
    endcase
  end

endmodule

// ===== sv/qmcds_mul.sv =====
// ----------------------------------------------------------------------------
// qmcds_mul: serial scale multiplier
// Shift-and-add multiplier that takes one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module qmcds_mul #(
  parameter int unsigned PW = 32
) (
  input  logic                                clk_i,
  input  qmcds_pkg::seq_ctrl_t                ctrl_i,
  input  logic [PW-1:0]                       mplr_i,
  input  logic [qmcds_pkg::ScaleW-1:0]        mcand_i,
  output logic [PW+qmcds_pkg::ScaleW-1:0]     prod_o
);

  logic [qmcds_pkg::ScaleW-1:0] hi_q, hi_d;
  logic [PW-1:0]                lo_q, lo_d;
  logic [qmcds_pkg::ScaleW:0]   sum;

  assign sum    = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_i} : '0);
  assign prod_o = {hi_q, lo_q};

  always_comb begin
    hi_d = hi_q;
    lo_d = lo_q;
    if (ctrl_i.load) begin
      hi_d = '0;
      lo_d = mplr_i;
    end else if (ctrl_i.step) begin
      // Product bits retire into the low half as the multiplier shifts out.
      hi_d = sum[qmcds_pkg::ScaleW:1];
      lo_d = {sum[0], lo_q[PW-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

endmodule

// ===== sv/qmcds_div.sv =====
// ----------------------------------------------------------------------------
// qmcds_div: serial restoring divider
// One quotient bit per cycle; the quotient shifts into the dividend register.
// ----------------------------------------------------------------------------
module qmcds_div #(
  parameter int unsigned XW = 33,
  parameter int unsigned DW = 17
) (
  input  logic                    clk_i,
  input  qmcds_pkg::seq_ctrl_t    ctrl_i,
  input  logic [XW-1:0]           x_i,
  input  logic [DW-1:0]           rem_i,
  input  logic [DW-1:0]           dvsr_i,
  output logic [XW-1:0]           quo_o,
  output logic [DW-1:0]           rem_o
);

  logic [XW-1:0] x_q, x_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  assign trial = {rem_q, x_q[XW-1]};
  assign diff  = trial - {1'b0, dvsr_i};
  assign fits  = trial >= {1'b0, dvsr_i};
  assign quo_o = x_q;
  assign rem_o = rem_q;

  always_comb begin
    x_d   = x_q;
    rem_d = rem_q;
    if (ctrl_i.load) begin
      x_d   = x_i;
      rem_d = rem_i;
    end else if (ctrl_i.step) begin
      // The partial remainder stays below the divisor, so DW bits hold it.
      rem_d = fits ? diff[DW-1:0] : trial[DW-1:0];
      x_d   = {x_q[XW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    rem_q <= rem_d;
  end

endmodule

// ===== sv/qmcds_mac.sv =====
// ----------------------------------------------------------------------------
// qmcds_mac: serial digit accumulator
// Adds digit times weight into the result and advances the weight by the
// base, one bit of digit and base per cycle, modulo 2^64.
// ----------------------------------------------------------------------------
module qmcds_mac (
  input  logic                              clk_i,
  input  qmcds_pkg::mac_ctrl_t              ctrl_i,
  input  logic [qmcds_pkg::BaseW-1:0]       digit_i,
  input  logic [qmcds_pkg::BaseW-1:0]       base_i,
  output logic [qmcds_pkg::AccW-1:0]        acc_o
);

  logic [qmcds_pkg::AccW-1:0]  acc_q, acc_d;
  logic [qmcds_pkg::AccW-1:0]  k_q, k_d;
  logic [qmcds_pkg::AccW-1:0]  ks_q, ks_d;
  logic [qmcds_pkg::AccW-1:0]  kn_q, kn_d;
  logic [qmcds_pkg::BaseW-1:0] dig_q, dig_d;
  logic [qmcds_pkg::BaseW-1:0] bsh_q, bsh_d;
  logic [qmcds_pkg::AccW-1:0]  acc_add;
  logic [qmcds_pkg::AccW-1:0]  kn_add;

  assign acc_add = acc_q + (dig_q[0] ? ks_q : '0);
  assign kn_add  = kn_q + (bsh_q[0] ? ks_q : '0);
  assign acc_o   = acc_q;

  always_comb begin
    acc_d = acc_q;
    k_d   = k_q;
    ks_d  = ks_q;
    kn_d  = kn_q;
    dig_d = dig_q;
    bsh_d = bsh_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
      k_d   = qmcds_pkg::AccW'(1);
    end else if (ctrl_i.load) begin
      ks_d  = k_q;
      kn_d  = '0;
      dig_d = digit_i;
      bsh_d = base_i;
    end else if (ctrl_i.step) begin
      acc_d = acc_add;
      kn_d  = kn_add;
      ks_d  = {ks_q[qmcds_pkg::AccW-2:0], 1'b0};
      dig_d = dig_q >> 1;
      bsh_d = bsh_q >> 1;
      if (ctrl_i.last) begin
        k_d = kn_add;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    k_q   <= k_d;
    ks_q  <= ks_d;
    kn_q  <= kn_d;
    dig_q <= dig_d;
    bsh_q <= bsh_d;
  end

endmodule

// ===== sv/qmc_point_digital_shift.sv =====
// ----------------------------------------------------------------------------
// qmc_point_digital_shift: quasi-Monte Carlo coordinate randomizer
// Shifts one Q0.FracBits coordinate per request by pass-through, addition
// modulo one or a digital shift in a configurable base.
// ----------------------------------------------------------------------------
// The block works on one request at a time and takes the next one once the
// current result has moved to the output register. Pass-through, add modulo
// one and a zero scale go from the start state straight to the finish state.
// The digital shift uses a serial multiplier of PW = min(FracBits, 32) bits
// and a restoring divider of FracBits quotient bits for the final division.
// Bases above two add a digit loop: for each base digit a restoring
// division of both digit integers and their sum, then a shift-and-add of
// digit and weight, for at most min(digit_count, 32) digits; the digit loop
// ends early once both digit integers are zero.
module qmc_point_digital_shift #(
  parameter int unsigned FracBits = qmcds_pkg::FracBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [qmcds_pkg::CfgAddrW-1:0]    paddr,
  input  logic [qmcds_pkg::CfgDataW-1:0]    pwdata,
  output logic [qmcds_pkg::CfgDataW-1:0]    prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [qmcds_pkg::DataW-1:0]       point_i,
  input  logic [qmcds_pkg::DataW-1:0]       shift_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [qmcds_pkg::DataW-1:0]       shifted_o
);

  localparam int unsigned PW       = (FracBits < qmcds_pkg::DataW) ? FracBits
                                                                   : qmcds_pkg::DataW;
  localparam int unsigned ProdW    = PW + qmcds_pkg::ScaleW;
  localparam int unsigned MaxSteps = (FracBits > qmcds_pkg::ScaleW) ? FracBits
                                                                    : qmcds_pkg::ScaleW;
  localparam int unsigned CntW     = $clog2(MaxSteps);
  localparam int unsigned DigW     = $clog2(qmcds_pkg::MaxDigits + 1);

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StStart  = 4'd1;
  localparam logic [3:0] StMul    = 4'd2;
  localparam logic [3:0] StScaled = 4'd3;
  localparam logic [3:0] StDstep  = 4'd4;
  localparam logic [3:0] StDiv    = 4'd5;
  localparam logic [3:0] StMacLd  = 4'd6;
  localparam logic [3:0] StMac    = 4'd7;
  localparam logic [3:0] StCheck  = 4'd8;
  localparam logic [3:0] StFdiv   = 4'd9;
  localparam logic [3:0] StFres   = 4'd10;
  localparam logic [3:0] StFinish = 4'd11;

  qmcds_pkg::cfg_t                  cfg;
  qmcds_pkg::seq_ctrl_t             mul_ctrl;
  qmcds_pkg::seq_ctrl_t             dig_ctrl;
  qmcds_pkg::seq_ctrl_t             fd_ctrl;
  qmcds_pkg::mac_ctrl_t             mac_ctrl;

  logic [3:0]                       state_q, state_d;
  logic [CntW-1:0]                  cnt_q, cnt_d;
  logic [DigW-1:0]                  dig_cnt_q, dig_cnt_d;
  logic [PW-1:0]                    pt_q, sh_q;
  logic [qmcds_pkg::DataW-1:0]      rslt_q, rslt_d;
  logic                             out_valid_q, out_valid_d;
  logic [qmcds_pkg::DataW-1:0]      out_data_q, out_data_d;
  logic                             accept;

  logic [PW-1:0]                    add_sum;
  logic                             base2;
  logic [DigW-1:0]                  n_digits;
  logic [ProdW-1:0]                 prod_p, prod_s;
  logic [qmcds_pkg::ScaleW-1:0]     pi, ri;
  logic [qmcds_pkg::ScaleW-1:0]     dp_x, dr_x, ds_x;
  logic [qmcds_pkg::ScaleW-1:0]     quo_p, quo_r;
  logic [qmcds_pkg::BaseW-1:0]      digit;
  logic [qmcds_pkg::AccW-1:0]       acc;
  logic [qmcds_pkg::AccW-1:0]       res64;
  logic [qmcds_pkg::ScaleW-1:0]     limit;
  logic [qmcds_pkg::ScaleW-1:0]     r33;
  logic [FracBits-1:0]              fq;

  qmcds_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  qmcds_mul #(.PW(PW)) u_mul_p (
    .clk_i   (clk_i),
    .ctrl_i  (mul_ctrl),
    .mplr_i  (pt_q),
    .mcand_i (cfg.scale),
    .prod_o  (prod_p)
  );

  qmcds_mul #(.PW(PW)) u_mul_s (
    .clk_i   (clk_i),
    .ctrl_i  (mul_ctrl),
    .mplr_i  (sh_q),
    .mcand_i (cfg.scale),
    .prod_o  (prod_s)
  );

  assign pi = qmcds_pkg::ScaleW'(prod_p >> FracBits);
  assign ri = qmcds_pkg::ScaleW'(prod_s >> FracBits);

  // The point and shift digit dividers first park the scaled integers, then divide
  // their own quotients again on every digit step; the third divides their sum.
  assign dp_x = (state_q == StScaled) ? pi : quo_p;
  assign dr_x = (state_q == StScaled) ? ri : quo_r;
  assign ds_x = quo_p + quo_r;

  qmcds_div #(.XW(qmcds_pkg::ScaleW), .DW(qmcds_pkg::BaseW)) u_div_p (
    .clk_i  (clk_i),
    .ctrl_i (dig_ctrl),
    .x_i    (dp_x),
    .rem_i  ('0),
    .dvsr_i (cfg.base),
    .quo_o  (quo_p),
    .rem_o  ()
  );

  qmcds_div #(.XW(qmcds_pkg::ScaleW), .DW(qmcds_pkg::BaseW)) u_div_r (
    .clk_i  (clk_i),
    .ctrl_i (dig_ctrl),
    .x_i    (dr_x),
    .rem_i  ('0),
    .dvsr_i (cfg.base),
    .quo_o  (quo_r),
    .rem_o  ()
  );

  qmcds_div #(.XW(qmcds_pkg::ScaleW), .DW(qmcds_pkg::BaseW)) u_div_s (
    .clk_i  (clk_i),
    .ctrl_i (dig_ctrl),
    .x_i    (ds_x),
    .rem_i  ('0),
    .dvsr_i (cfg.base),
    .quo_o  (),
    .rem_o  (digit)
  );

  qmcds_mac u_mac (
    .clk_i   (clk_i),
    .ctrl_i  (mac_ctrl),
    .digit_i (digit),
    .base_i  (cfg.base),
    .acc_o   (acc)
  );

  // A digit integer of one modulo one wraps to zero; in base two only values
  // that do not fit below the scale are dropped.
  assign res64 = base2 ? qmcds_pkg::AccW'(quo_p ^ quo_r) : acc;
  assign limit = base2 ? cfg.scale : cfg.scale - 1'b1;
  assign r33   = (res64 >= qmcds_pkg::AccW'(limit)) ? '0 : res64[qmcds_pkg::ScaleW-1:0];

  qmcds_div #(.XW(FracBits), .DW(qmcds_pkg::ScaleW)) u_div_f (
    .clk_i  (clk_i),
    .ctrl_i (fd_ctrl),
    .x_i    ('0),
    .rem_i  (r33),
    .dvsr_i (cfg.scale),
    .quo_o  (fq),
    .rem_o  ()
  );

  assign add_sum  = pt_q + sh_q;
  assign base2    = cfg.base <= qmcds_pkg::BaseTwo;
  assign n_digits = (cfg.digit_count > qmcds_pkg::DcntW'(qmcds_pkg::MaxDigits))
                    ? DigW'(qmcds_pkg::MaxDigits) : DigW'(cfg.digit_count);

  assign in_stall_o  = state_q != StIdle;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign shifted_o   = out_data_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    dig_cnt_d   = dig_cnt_q;
    rslt_d      = rslt_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    mul_ctrl    = '0;
    dig_ctrl    = '0;
    fd_ctrl     = '0;
    mac_ctrl    = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StStart;
        end
      end
      StStart: begin
        case (cfg.method)
          qmcds_pkg::MethodAdd: begin
            rslt_d  = qmcds_pkg::DataW'(add_sum);
            state_d = StFinish;
          end
          qmcds_pkg::MethodDigital: begin
            if (cfg.scale == '0) begin
              rslt_d  = '0;
              state_d = StFinish;
            end else begin
              mul_ctrl.load = 1'b1;
              cnt_d         = '0;
              state_d       = StMul;
            end
          end
          default: begin
            rslt_d  = qmcds_pkg::DataW'(pt_q);
            state_d = StFinish;
          end
        endcase
      end
      StMul: begin
        mul_ctrl.step = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == CntW'(PW - 1)) begin
          state_d = StScaled;
        end
      end
      StScaled: begin
        dig_ctrl.load = 1'b1;
        if (base2) begin
          state_d = StCheck;
        end else begin
          mac_ctrl.clear = 1'b1;
          dig_cnt_d      = '0;
          state_d        = StDstep;
        end
      end
      StDstep: begin
        // Once both integers are zero every further digit is zero as well.
        if (dig_cnt_q == n_digits || (quo_p == '0 && quo_r == '0)) begin
          state_d = StCheck;
        end else begin
          dig_ctrl.load = 1'b1;
          cnt_d         = '0;
          state_d       = StDiv;
        end
      end
      StDiv: begin
        dig_ctrl.step = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == CntW'(qmcds_pkg::ScaleW - 1)) begin
          state_d = StMacLd;
        end
      end
      StMacLd: begin
        mac_ctrl.load = 1'b1;
        cnt_d         = '0;
        state_d       = StMac;
      end
      StMac: begin
        mac_ctrl.step = 1'b1;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == CntW'(qmcds_pkg::BaseW - 1)) begin
          mac_ctrl.last = 1'b1;
          dig_cnt_d     = dig_cnt_q + 1'b1;
          state_d       = StDstep;
        end
      end
      StCheck: begin
        fd_ctrl.load = 1'b1;
        cnt_d        = '0;
        state_d      = StFdiv;
      end
      StFdiv: begin
        fd_ctrl.step = 1'b1;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == CntW'(FracBits - 1)) begin
          state_d = StFres;
        end
      end
      StFres: begin
        rslt_d  = qmcds_pkg::DataW'(fq);
        state_d = StFinish;
      end
      StFinish: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d  = rslt_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      dig_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dig_cnt_q   <= dig_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pt_q <= point_i[PW-1:0];
      sh_q <= shift_i[PW-1:0];
    end
    rslt_q     <= rslt_d;
    out_data_q <= out_data_d;
  end

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == StStart))
    else $error("accepted request did not start the sequencer");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StFinish))
    else $error("output became valid outside the finish state");

  a_finish_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFinish && !out_stall_i) |=> (out_valid_q && state_q == StIdle))
    else $error("finished result was not moved to the output register");

  a_digit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMac || state_q == StDiv) |-> (dig_cnt_q < DigW'(qmcds_pkg::MaxDigits)))
    else $error("digit loop ran past the digit limit");
`endif

endmodule

// ===== dv/tb_qmc_point_digital_shift.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_qmc_point_digital_shift: self-checking bench of the coordinate randomizer
// Steps through a series of register settings and runs random requests under
// each, directed ones under some. A cycle-free predictor works out the
// shifted coordinate of every accepted request, and a monitor compares each
// result with the oldest prediction. Both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module tb_qmc_point_digital_shift;

  localparam logic [qmcds_pkg::MethodW-1:0] MethodUnused = 2'd3;
  localparam int unsigned        HoldCycles   = 300;
  localparam int unsigned        IdleLimit    = 20000;
  localparam int unsigned        TailCycles   = 200;

  typedef struct packed {
    logic [qmcds_pkg::DataW-1:0] pt;
    logic [qmcds_pkg::DataW-1:0] sft;
  } coord_req_t;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           psel        = 1'b0;
  logic                           penable     = 1'b0;
  logic                           pwrite      = 1'b0;
  logic [qmcds_pkg::CfgAddrW-1:0] paddr       = '0;
  logic [qmcds_pkg::CfgDataW-1:0] pwdata      = '0;
  logic [qmcds_pkg::CfgDataW-1:0] prdata;
  logic                           pready;
  logic                           in_valid_i  = 1'b0;
  logic                           in_stall_o;
  logic [qmcds_pkg::DataW-1:0]    point_i     = '0;
  logic [qmcds_pkg::DataW-1:0]    shift_i     = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [qmcds_pkg::DataW-1:0]    shifted_o;

  // Register copies used by the predictor.
  logic [qmcds_pkg::MethodW-1:0]  cfg_method = qmcds_pkg::MethodReset;
  logic [qmcds_pkg::BaseW-1:0]    cfg_base   = qmcds_pkg::BaseReset;
  logic [qmcds_pkg::DcntW-1:0]    cfg_dcnt   = qmcds_pkg::DcntReset;
  logic [qmcds_pkg::ScaleW-1:0]   cfg_scale  = qmcds_pkg::ScaleReset;

  coord_req_t                     pending_reqs[$];
  logic [qmcds_pkg::DataW-1:0]    shifted_due[$];

  int unsigned         send_idle_pct = 28;
  int unsigned         recv_idle_pct = 28;
  int unsigned         hold_asked    = 0;
  int unsigned         hold_served   = 0;
  int unsigned         hold_left     = 0;
  int unsigned         idle_cycles   = 0;
  int unsigned         n_sent        = 0;
  int unsigned         n_checked     = 0;
  int unsigned         n_settings    = 0;
  int unsigned         n_errors      = 0;

  qmc_point_digital_shift u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .point_i     (point_i),
    .shift_i     (shift_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .shifted_o   (shifted_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    n_errors++;
    if (n_errors <= 10) begin
      $display("MISMATCH %s: expected %h, got %h", what, want, got);
    end
  endfunction

  // Shifted coordinate of one request under the current register settings.
  function automatic logic [qmcds_pkg::DataW-1:0] shift_coord(
      input logic [qmcds_pkg::DataW-1:0] pt,
      input logic [qmcds_pkg::DataW-1:0] sft);
    logic [63:0]  radix, sc, pdig, sdig, acc, weight, digit_sum, n_digits, rem, quo;
    logic [127:0] prod;
    if (cfg_method == qmcds_pkg::MethodAdd) begin
      return pt + sft;
    end
    if (cfg_method != qmcds_pkg::MethodDigital) begin
      return pt;
    end
    sc = 64'(cfg_scale);
    if (sc == 0) begin
      return '0;
    end
    radix = (cfg_base < qmcds_pkg::BaseTwo) ? 64'd2 : 64'(cfg_base);
    prod  = 128'(pt) * 128'(sc);
    pdig  = 64'(prod >> qmcds_pkg::DataW);
    prod  = 128'(sft) * 128'(sc);
    sdig  = 64'(prod >> qmcds_pkg::DataW);
    if (radix == 64'd2) begin
      acc = pdig ^ sdig;
      if (acc >= sc) begin
        acc = '0;
      end
    end else begin
      n_digits = (cfg_dcnt > qmcds_pkg::MaxDigits) ? 64'(qmcds_pkg::MaxDigits)
                                                   : 64'(cfg_dcnt);
      acc      = '0;
      weight   = 64'd1;
      for (int j = 0; j < n_digits; j++) begin
        digit_sum = (pdig + sdig) & 64'h1_FFFF_FFFF;
        acc       = acc + (digit_sum % radix) * weight;
        pdig      = pdig / radix;
        sdig      = sdig / radix;
        weight    = weight * radix;
      end
      // A digit integer of scale-1 or more would be one modulo one.
      if (acc >= sc - 1) begin
        acc = '0;
      end
    end
    rem = acc;
    quo = '0;
    for (int j = 0; j < qmcds_pkg::DataW; j++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= sc) begin
        rem    = rem - sc;
        quo[0] = 1'b1;
      end
    end
    return quo[qmcds_pkg::DataW-1:0];
  endfunction

  function automatic logic [qmcds_pkg::CfgDataW-1:0] cfg_value(
      input logic [qmcds_pkg::RegIdxW-1:0] idx);
    case (idx)
      qmcds_pkg::RegMethod: return qmcds_pkg::CfgDataW'(cfg_method);
      qmcds_pkg::RegBase:   return qmcds_pkg::CfgDataW'(cfg_base);
      qmcds_pkg::RegDcnt:   return qmcds_pkg::CfgDataW'(cfg_dcnt);
      default:              return qmcds_pkg::CfgDataW'(cfg_scale);
    endcase
  endfunction

  function automatic logic [qmcds_pkg::DataW-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      // Small values let the digit loop finish early.
      2:       return qmcds_pkg::DataW'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  task automatic push_req(input logic [qmcds_pkg::DataW-1:0] pt,
                          input logic [qmcds_pkg::DataW-1:0] sft);
    coord_req_t req;
    req.pt  = pt;
    req.sft = sft;
    pending_reqs.push_back(req);
  endtask

  task automatic push_random(input int unsigned count);
    repeat (count) push_req(rand_coord(), rand_coord());
  endtask

  // Holds back the caller until every request has been sent and answered.
  task automatic drain();
    while (pending_reqs.size() != 0 || in_valid_i || shifted_due.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Each transfer ends on its completion edge and leaves the bus to the next one.
  task automatic apb_write(input logic [qmcds_pkg::RegIdxW-1:0]  idx,
                           input logic [qmcds_pkg::CfgDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      qmcds_pkg::RegMethod: cfg_method = value[qmcds_pkg::MethodW-1:0];
      qmcds_pkg::RegBase:   cfg_base   = value[qmcds_pkg::BaseW-1:0];
      qmcds_pkg::RegDcnt:   cfg_dcnt   = value[qmcds_pkg::DcntW-1:0];
      default:              cfg_scale  = value[qmcds_pkg::ScaleW-1:0];
    endcase
  endtask

  task automatic apb_read(input  logic [qmcds_pkg::RegIdxW-1:0]  idx,
                          output logic [qmcds_pkg::CfgDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 3'b000};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    value = prdata;
  endtask

  task automatic set_config(input logic [qmcds_pkg::MethodW-1:0] m,
                            input logic [qmcds_pkg::BaseW-1:0]   b,
                            input logic [qmcds_pkg::DcntW-1:0]   d,
                            input logic [qmcds_pkg::ScaleW-1:0]  s);
    logic [qmcds_pkg::CfgDataW-1:0] rd;
    drain();
    apb_write(qmcds_pkg::RegMethod, qmcds_pkg::CfgDataW'(m));
    apb_write(qmcds_pkg::RegBase, qmcds_pkg::CfgDataW'(b));
    apb_write(qmcds_pkg::RegDcnt, qmcds_pkg::CfgDataW'(d));
    apb_write(qmcds_pkg::RegScale, qmcds_pkg::CfgDataW'(s));
    for (int i = 0; i < 4; i++) begin
      apb_read(qmcds_pkg::RegIdxW'(i), rd);
      if (rd !== cfg_value(qmcds_pkg::RegIdxW'(i))) begin
        note_mismatch($sformatf("register %0d readback", i),
                      cfg_value(qmcds_pkg::RegIdxW'(i)), rd);
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    n_settings++;
  endtask

  // Request driver: a request stays on the bus until it is taken.
  always @(posedge clk_i) begin : drive_reqs
    coord_req_t req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        shifted_due.push_back(shift_coord(point_i, shift_i));
        n_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          point_i    <= req.pt;
          shift_i    <= req.sft;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver stall, with a long hold-off whenever one is asked for.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    logic [qmcds_pkg::DataW-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_checked++;
      if (shifted_due.size() == 0) begin
        note_mismatch("result with no request outstanding", '0, shifted_o);
      end else begin
        want = shifted_due.pop_front();
        if (shifted_o !== want) begin
          note_mismatch($sformatf("shifted of result %0d", n_checked), want, shifted_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Timeout: no request or result moved for %0d cycles", IdleLimit);
      $display("qmc_point_digital_shift test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Settings after reset: the point passes through.
    push_req('0, '0);
    push_req('1, '1);
    push_req(32'h8000_0000, 32'h0000_0001);
    push_req(32'h0000_0001, 32'h8000_0000);
    push_random(50);

    set_config(qmcds_pkg::MethodAdd, qmcds_pkg::BaseTwo, qmcds_pkg::DcntReset,
               qmcds_pkg::ScaleReset);
    push_req(32'h8000_0000, 32'h8000_0000);  // a sum of exactly one wraps to zero
    push_req('1, '1);
    push_req('1, 32'h0000_0001);
    push_random(100);
    // The receiver holds off while requests keep coming, so the block backs up.
    hold_asked++;

    set_config(qmcds_pkg::MethodDigital, qmcds_pkg::BaseTwo, qmcds_pkg::DcntReset,
               qmcds_pkg::ScaleReset);
    push_req('1, '0);
    push_req('1, '1);
    push_req(32'hAAAA_AAAA, 32'h5555_5555);
    push_random(140);

    set_config(qmcds_pkg::MethodDigital, qmcds_pkg::BaseTwo, 6'd5, 33'd32);
    push_random(50);

    // Scale three in base two: an XOR of one and two lands on the scale.
    set_config(qmcds_pkg::MethodDigital, qmcds_pkg::BaseTwo, 6'd2, 33'd3);
    push_req(32'h5555_5556, 32'hAAAA_AAAB);
    push_random(40);

    set_config(qmcds_pkg::MethodDigital, 17'd3, 6'd3, 33'd27);
    push_random(70);

    set_config(qmcds_pkg::MethodDigital, 17'd10, 6'd2, 33'd100);
    push_random(70);

    set_config(qmcds_pkg::MethodDigital, 17'd65536, 6'd2, qmcds_pkg::ScaleReset);
    push_random(50);

    set_config(qmcds_pkg::MethodDigital, 17'h1_FFFF, 6'd1, 33'h1_FFFF);
    push_random(20);

    // All digits two in base three give scale-1, which must come out as zero.
    set_config(qmcds_pkg::MethodDigital, 17'd3, 6'd20, 33'd3486784401);
    push_req('1, '0);
    push_req('1, '1);
    push_random(15);

    // More digits than the block handles.
    set_config(qmcds_pkg::MethodDigital, 17'd7, 6'd40, 33'd1977326743);
    push_random(10);

    // Bases below two fall back to the XOR path.
    set_config(qmcds_pkg::MethodDigital, 17'd1, 6'd0, 33'd2);
    push_random(15);
    set_config(qmcds_pkg::MethodDigital, 17'd0, 6'd1, 33'd2);
    push_random(15);

    // No digits at all in base six.
    set_config(qmcds_pkg::MethodDigital, 17'd6, 6'd0, 33'd36);
    push_random(10);

    set_config(qmcds_pkg::MethodDigital, 17'd5, 6'd4, 33'd0);
    push_req('1, '1);
    push_random(10);

    // The unused method code passes the point through.
    set_config(MethodUnused, 17'h1_FFFF, 6'd63, 33'h1_FFFF_FFFF);
    push_req('1, 32'h1234_5678);
    push_random(25);

    set_config(qmcds_pkg::MethodDigital, qmcds_pkg::BaseTwo, 6'd63, 33'h1_FFFF_FFFF);
    push_random(20);

    // A stretch at full rate on both sides.
    set_config(qmcds_pkg::MethodAdd, qmcds_pkg::BaseTwo, qmcds_pkg::DcntReset,
               qmcds_pkg::ScaleReset);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random(90);
    drain();
    send_idle_pct = 28;
    recv_idle_pct = 28;

    set_config(qmcds_pkg::MethodDigital, 17'd5, 6'd13, 33'd1220703125);
    push_random(40);

    drain();
    repeat (TailCycles) @(posedge clk_i);
    $display("Covered %0d requests under %0d register settings, all methods and bases 0..65536+",
             n_sent, n_settings + 1);
    $display("Checked %0d results, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("qmc_point_digital_shift test passed");
    end else begin
      $display("qmc_point_digital_shift test failed");
    end
    $finish;
  end

endmodule
